// ----- hw/rtl/hrrp_pkg.sv -----
// shared types and codes for the health aware round robin picker
`timescale 1ns / 1ps

package hrrp_pkg;

    // field widths
    localparam int ADDR_W   = 48;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_HEALTH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_PICKED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd6;

    // command payload
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] backend_addr;
        logic              is_healthy;
    } cmd_t;

    // result payload
    typedef struct packed {
        logic [ADDR_W-1:0]   chosen_addr;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  healthy_count;
    } result_t;

endpackage

// ----- hw/rtl/health_aware_round_robin_picker.sv -----
// round robin picker over a list of healthy backends kept in a ram; a pick reads the entry
// at the pointer and advances it; an empty pick or unused code is answered without a ram
// read; health/remove walk the list, an up report adds at the end on a miss, a delete moves
// later entries down; one command at a time, the next may transfer with the result; the single
// ram read port walking the list sets the time; reset: count and pointer clear asynchronously,
// list contents stay undefined until written; results are strobed, the receiver cannot stall
`timescale 1ns / 1ps

module health_aware_round_robin_picker #(
    parameter int MAX_BACKENDS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  hrrp_pkg::cmd_t  cmd,
    output logic            done,
    output hrrp_pkg::result_t result
);

    localparam int IW  = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int CW  = $clog2(MAX_BACKENDS + 1);
    localparam int OCW = hrrp_pkg::COUNT_W;
    localparam int AW  = hrrp_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PICK   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_SHIFT  = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [IW-1:0]              ptr_reg, ptr_next;
    logic [hrrp_pkg::OP_W-1:0]  op_reg, op_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic                       up_reg, up_next;
    logic [CW-1:0]              rd_idx_reg, rd_idx_next;
    logic                       cmp_v_reg, cmp_v_next;
    logic [IW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                       pend_reg, pend_next;
    logic [IW-1:0]              wr_idx_reg, wr_idx_next;
    logic                       done_reg, done_next;
    hrrp_pkg::result_t          result_reg, result_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [AW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [AW-1:0] ram_rdata;

    logic          del_mode;
    logic          match;
    logic [CW-1:0] ptr_plus;
    logic [CW-1:0] count_dec;

    // list storage
    hrrp_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_BACKENDS)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // helpers
    assign del_mode  = (op_reg == hrrp_pkg::OP_REMOVE) || !up_reg;
    assign match     = cmp_v_reg && (ram_rdata == addr_reg);
    assign ptr_plus  = CW'(ptr_reg) + CW'(1);
    assign count_dec = count_reg - CW'(1);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        up_next      = up_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_v_next   = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = 1'b0;
        wr_idx_next  = wr_idx_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_idx_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = cmd.operation;
                    addr_next = cmd.backend_addr;
                    up_next   = cmd.is_healthy;
                    case (cmd.operation)
                        hrrp_pkg::OP_PICK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next               = 1'b1;
                                result_next.chosen_addr = '0;
                                result_next.status      = hrrp_pkg::ST_NONE;
                                result_next.healthy_count = OCW'(count_reg);
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ptr_reg;
                                state_next = S_PICK;
                            end
                        end
                        hrrp_pkg::OP_HEALTH, hrrp_pkg::OP_REMOVE:
                        begin
                            rd_idx_next = '0;
                            state_next  = S_SEARCH;
                        end
                        default:
                        begin
                            done_next               = 1'b1;
                            result_next.chosen_addr = '0;
                            result_next.status      = hrrp_pkg::ST_ABSENT;
                            result_next.healthy_count = OCW'(count_reg);
                        end
                    endcase
                end
            end

            // read data for the pick is back
            S_PICK:
            begin
                done_next               = 1'b1;
                result_next.chosen_addr = ram_rdata;
                result_next.status      = hrrp_pkg::ST_PICKED;
                result_next.healthy_count = OCW'(count_reg);
                ptr_next   = (ptr_plus >= count_reg) ? '0 : ptr_plus[IW-1:0];
                state_next = S_IDLE;
            end

            // pipelined walk: compare last read while issuing the next one
            S_SEARCH:
            begin
                if (match)
                begin
                    if (del_mode)
                    begin
                        rd_idx_next = CW'(cmp_idx_reg) + CW'(1);
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        done_next               = 1'b1;
                        result_next.chosen_addr = '0;
                        result_next.status      = hrrp_pkg::ST_PRESENT;
                        result_next.healthy_count = OCW'(count_reg);
                        state_next              = S_IDLE;
                    end
                end
                else if (rd_idx_reg < count_reg)
                begin
                    ram_re       = 1'b1;
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = rd_idx_reg[IW-1:0];
                    rd_idx_next  = rd_idx_reg + CW'(1);
                end
                else
                begin
                    done_next               = 1'b1;
                    result_next.chosen_addr = '0;
                    result_next.healthy_count = OCW'(count_reg);
                    state_next              = S_IDLE;
                    if (del_mode)
                    begin
                        result_next.status = hrrp_pkg::ST_ABSENT;
                    end
                    else if (count_reg >= CW'(MAX_BACKENDS))
                    begin
                        result_next.status = hrrp_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IW-1:0];
                        ram_wdata  = addr_reg;
                        count_next = count_reg + CW'(1);
                        result_next.status = hrrp_pkg::ST_ADDED;
                        result_next.healthy_count = OCW'(count_next);
                    end
                end
            end

            // move later entries down one place
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (rd_idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    pend_next   = 1'b1;
                    wr_idx_next = rd_idx_reg[IW-1:0] - IW'(1);
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_dec;
                    if (CW'(ptr_reg) >= count_dec)
                    begin
                        ptr_next = '0;
                    end
                    done_next               = 1'b1;
                    result_next.chosen_addr = '0;
                    result_next.status      = hrrp_pkg::ST_REMOVED;
                    result_next.healthy_count = OCW'(count_dec);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            cmp_v_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            cmp_v_reg <= cmp_v_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        up_reg      <= up_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        wr_idx_reg  <= wr_idx_next;
        result_reg  <= result_next;
    end

    // outputs
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && (count_reg != '0) |-> (CW'(ptr_reg) < count_reg))
        else $error("round robin pointer at or past entry count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BACKENDS))
        else $error("entry count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while a command is still in flight");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) || (state_reg == S_PICK) |-> !ram_we)
        else $error("list write outside search or compaction");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && (state_reg == S_SHIFT) |-> (CW'(wr_idx_reg) < count_dec))
        else $error("compaction write beyond the shrunken list");

endmodule

// ----- hw/rtl/hrrp_ram.sv -----
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module hrrp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ----- tb/picker_checker.sv -----
// scoreboard for the round robin picker: predicts each result and compares it
`timescale 1ns / 1ps

module picker_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  hrrp_pkg::cmd_t    cmd,
    input  logic              done,
    input  hrrp_pkg::result_t result,
    output int                fail_count,
    output int                pending
);

    localparam int TABLE_DEPTH = 16;
    localparam int REPORT_MAX  = 10;
    localparam int QUEUE_DEPTH = 4;

    // shadow copy of the healthy list, its length and the round robin pointer
    logic [hrrp_pkg::ADDR_W-1:0]  backends [TABLE_DEPTH];
    logic [hrrp_pkg::COUNT_W-1:0] live_count = '0;
    logic [3:0]                   rr_ptr = '0;

    // results still owed by the block, oldest at the head
    hrrp_pkg::result_t awaited_outcomes [QUEUE_DEPTH];
    int                q_head   = 0;
    int                q_tail   = 0;
    int                reported = 0;

    // position of addr in the list, or the list length when absent
    function automatic int locate_backend(input logic [hrrp_pkg::ADDR_W-1:0] addr);
        int i;
        for (i = 0; i < live_count; i++)
        begin
            if (backends[i] == addr)
                return i;
        end
        return int'(live_count);
    endfunction

    // delete addr, close the gap, pull the pointer back to zero if it ran past the end
    function automatic logic [hrrp_pkg::STATUS_W-1:0] drop_backend(
        input logic [hrrp_pkg::ADDR_W-1:0] addr);
        int pos;
        int i;
        pos = locate_backend(addr);
        if (pos >= live_count)
            return hrrp_pkg::ST_ABSENT;
        for (i = pos; i + 1 < live_count; i++)
            backends[i] = backends[i + 1];
        live_count = live_count - 1'b1;
        if ({1'b0, rr_ptr} >= live_count)
            rr_ptr = '0;
        return hrrp_pkg::ST_REMOVED;
    endfunction

    // apply one command to the shadow state and return the outcome it causes
    function automatic hrrp_pkg::result_t compute_outcome(input hrrp_pkg::cmd_t c);
        hrrp_pkg::result_t            r;
        logic [hrrp_pkg::COUNT_W-1:0] nxt;
        r = '0;
        case (c.operation)
            hrrp_pkg::OP_PICK:
            begin
                if (live_count == 0)
                    r.status = hrrp_pkg::ST_NONE;
                else
                begin
                    r.chosen_addr = backends[rr_ptr];
                    nxt = {1'b0, rr_ptr} + 1'b1;
                    rr_ptr = (nxt >= live_count) ? 4'd0 : nxt[3:0];
                    r.status = hrrp_pkg::ST_PICKED;
                end
            end
            hrrp_pkg::OP_HEALTH:
            begin
                if (!c.is_healthy)
                    r.status = drop_backend(c.backend_addr);
                else if (locate_backend(c.backend_addr) < live_count)
                    r.status = hrrp_pkg::ST_PRESENT;
                else if (live_count >= TABLE_DEPTH)
                    r.status = hrrp_pkg::ST_FULL;
                else
                begin
                    backends[live_count[3:0]] = c.backend_addr;
                    live_count = live_count + 1'b1;
                    r.status = hrrp_pkg::ST_ADDED;
                end
            end
            hrrp_pkg::OP_REMOVE:
                r.status = drop_backend(c.backend_addr);
            default:
                r.status = hrrp_pkg::ST_ABSENT;
        endcase
        r.healthy_count = live_count;
        return r;
    endfunction

    // compare results against the oldest prediction, then predict for a new transfer
    always @(posedge clk or negedge rst_n)
    begin
        hrrp_pkg::result_t exp_r;
        if (!rst_n)
        begin
            live_count = '0;
            rr_ptr     = '0;
            q_head     = 0;
            q_tail     = 0;
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending == 0)
                begin
                    fail_count++;
                    if (reported < REPORT_MAX)
                        $display("%0t: result with nothing pending: addr=%h status=%0d count=%0d",
                                 $realtime, result.chosen_addr, result.status,
                                 result.healthy_count);
                    reported++;
                end
                else
                begin
                    exp_r  = awaited_outcomes[q_head];
                    q_head = (q_head + 1) % QUEUE_DEPTH;
                    pending--;
                    if (result.chosen_addr !== exp_r.chosen_addr
                        || result.status !== exp_r.status
                        || result.healthy_count !== exp_r.healthy_count)
                    begin
                        fail_count++;
                        if (reported < REPORT_MAX)
                            $display({"%0t: mismatch: expected addr=%h status=%0d count=%0d,",
                                      " got addr=%h status=%0d count=%0d"},
                                     $realtime, exp_r.chosen_addr, exp_r.status,
                                     exp_r.healthy_count, result.chosen_addr,
                                     result.status, result.healthy_count);
                        reported++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (pending >= QUEUE_DEPTH)
                begin
                    fail_count++;
                    if (reported < REPORT_MAX)
                        $display("%0t: transfer while %0d results are still owed",
                                 $realtime, pending);
                    reported++;
                end
                else
                begin
                    awaited_outcomes[q_tail] = compute_outcome(cmd);
                    q_tail = (q_tail + 1) % QUEUE_DEPTH;
                    pending++;
                end
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// top of the picker testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    // operation code the block does not define
    localparam logic [hrrp_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int TAIL_CYCLES   = 64;
    localparam int RANDOM_BLOCKS = 10;
    localparam int BLOCK_ITEMS   = 100;
    localparam int POOL_SIZE     = 20;

    typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    hrrp_pkg::cmd_t    cmd;
    logic              done;
    hrrp_pkg::result_t result;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    bit                quiet_block;

    // small address pool so that adds, duplicates and deletes hit each other
    logic [hrrp_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

    health_aware_round_robin_picker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    picker_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [hrrp_pkg::ADDR_W-1:0] random_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[hrrp_pkg::ADDR_W-1:0];
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_block || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // hold one command until its transfer, called at a falling edge
    task automatic send_cmd(input logic [hrrp_pkg::OP_W-1:0] op,
                            input logic [hrrp_pkg::ADDR_W-1:0] addr,
                            input logic healthy);
        int gap;
        start = 1'b1;
        cmd.operation    = op;
        cmd.backend_addr = addr;
        cmd.is_healthy   = healthy;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic random_item(input mix_t mix);
        int                          r;
        int                          lim_pick;
        int                          lim_up;
        int                          lim_down;
        int                          lim_rem;
        logic [hrrp_pkg::ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        case (mix)
            MIX_GROW:
            begin
                lim_pick = 30; lim_up = 85; lim_down = 90; lim_rem = 95;
            end
            MIX_CHURN:
            begin
                lim_pick = 45; lim_up = 70; lim_down = 82; lim_rem = 94;
            end
            default:
            begin
                lim_pick = 30; lim_up = 40; lim_down = 65; lim_rem = 95;
            end
        endcase
        if (r < lim_pick)
            send_cmd(hrrp_pkg::OP_PICK, random_addr(), 1'($urandom_range(0, 1)));
        else if (r < lim_up)
            send_cmd(hrrp_pkg::OP_HEALTH, a, 1'b1);
        else if (r < lim_down)
            send_cmd(hrrp_pkg::OP_HEALTH, a, 1'b0);
        else if (r < lim_rem)
            send_cmd(hrrp_pkg::OP_REMOVE, a, 1'($urandom_range(0, 1)));
        else
            send_cmd(hrrp_pkg::OP_W'($urandom_range(0, 3)), random_addr(),
                     1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int   i;
        int   blk;
        mix_t mix;
        start       = 1'b0;
        cmd         = '0;
        rst_n       = 1'b0;
        quiet_block = 1'b0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = random_addr();

        // reset
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty list cases and the unused code
        send_cmd(hrrp_pkg::OP_PICK, random_addr(), 1'b1);
        send_cmd(hrrp_pkg::OP_REMOVE, '1, 1'b0);
        send_cmd(hrrp_pkg::OP_HEALTH, '1, 1'b0);
        send_cmd(OP_SPARE, random_addr(), 1'b1);
        // address extremes, duplicate add
        send_cmd(hrrp_pkg::OP_HEALTH, '0, 1'b1);
        send_cmd(hrrp_pkg::OP_HEALTH, '1, 1'b1);
        send_cmd(hrrp_pkg::OP_HEALTH, '0, 1'b1);
        // picks wrap around, stray fields ignored
        send_cmd(hrrp_pkg::OP_PICK, '1, 1'b1);
        send_cmd(hrrp_pkg::OP_PICK, '0, 1'b0);
        send_cmd(hrrp_pkg::OP_PICK, random_addr(), 1'b1);
        // pointer sits at the end, delete pulls it back to zero
        send_cmd(hrrp_pkg::OP_REMOVE, '0, 1'b1);
        // fill the table, then one more add is refused
        for (i = 2; i < 17; i++)
            send_cmd(hrrp_pkg::OP_HEALTH, addr_pool[i], 1'b1);
        send_cmd(hrrp_pkg::OP_HEALTH, addr_pool[17], 1'b1);
        // down report at the head shifts the whole list
        send_cmd(hrrp_pkg::OP_HEALTH, '1, 1'b0);
        drain();

        // random blocks cycling through growth, churn and shrink mixes
        for (blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            mix = mix_t'(blk % 3);
            quiet_block = ($urandom_range(0, 3) == 0);
            if (blk == 4 || blk == 7)
                drain();
            for (i = 0; i < BLOCK_ITEMS; i++)
                random_item(mix);
        end

        // wind down
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
